@@ hdl/lgct_pkg.sv @@
// ----------------------------------------------------------------------------
// lgct_pkg
// Types and constants shared by the linear gradient color tint block.
// ----------------------------------------------------------------------------
package lgct_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int PosW     = 16;
  localparam int DeltaW   = PosW + 1;
  localparam int GradW    = 32;
  localparam int ProdW    = DeltaW + GradW;
  localparam int SumW     = ProdW + 1;
  localparam int ChanW    = 8;
  localparam int TW       = 17;
  localparam int TShift   = 12;
  localparam logic [TW-1:0] TOne = TW'(65536);

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_CONST  = 2'd1,
    MODE_LINEAR = 2'd2,
    MODE_LOCAL  = 2'd3
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE        = 3'd0,
    CFG_START_X     = 3'd1,
    CFG_START_Y     = 3'd2,
    CFG_GRAD_X      = 3'd3,
    CFG_GRAD_Y      = 3'd4,
    CFG_COLOR_START = 3'd5,
    CFG_COLOR_END   = 3'd6
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_PASS   = 2'd0,
    KIND_CONST  = 2'd1,
    KIND_LINEAR = 2'd2
  } kind_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } rgba_t;

  typedef struct packed {
    mode_t                    mode;
    logic signed [PosW-1:0]   start_x;
    logic signed [PosW-1:0]   start_y;
    logic signed [GradW-1:0]  grad_x;
    logic signed [GradW-1:0]  grad_y;
    rgba_t                    color_start;
    rgba_t                    color_end;
  } cfg_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
    rgba_t                    color;
  } item_t;

endpackage

@@ hdl/lgct_front.sv @@
// ----------------------------------------------------------------------------
// lgct_front
// Input stage: takes a point transfer, classifies it by mode and forms the
// offsets from the gradient start.
// ----------------------------------------------------------------------------
module lgct_front import lgct_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [PosW-1:0] pos_x,
  input  logic signed [PosW-1:0] pos_y,
  input  rgba_t                  in_color,
  output logic                   item_valid,
  input  logic                   item_ready,
  output item_t                  item
);

  logic  valid;
  item_t item_next;

  assign in_ready   = !valid || item_ready;
  assign item_valid = valid;

  always_comb begin
    case (cfg.mode)
      MODE_NONE:   item_next.kind = KIND_PASS;
      MODE_CONST:  item_next.kind = KIND_CONST;
      default:     item_next.kind = KIND_LINEAR;
    endcase
    item_next.dx    = DeltaW'(pos_x) - DeltaW'(cfg.start_x);
    item_next.dy    = DeltaW'(pos_y) - DeltaW'(cfg.start_y);
    item_next.color = in_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

@@ hdl/lgct_queue.sv @@
// ----------------------------------------------------------------------------
// lgct_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module lgct_queue import lgct_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_ready,
  output item_t rd_item
);

  item_t       mem [2];
  logic        head;
  logic        tail;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = mem[head];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        tail <= !tail;
      end
      if (pop) begin
        head <= !head;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= wr_item;
    end
  end

endmodule

@@ hdl/lgct_back.sv @@
// ----------------------------------------------------------------------------
// lgct_back
// Four-stage datapath: axis products, clamped position, blended tint,
// channel modulation into the output register.
// ----------------------------------------------------------------------------
module lgct_back import lgct_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  output logic  out_valid,
  input  logic  out_ready,
  output rgba_t out_color
);

  function automatic logic [ChanW-1:0] blend(input logic [ChanW-1:0] a,
                                             input logic [ChanW-1:0] b,
                                             input logic [TW-1:0] t);
    logic signed [ChanW:0]      diff;
    logic signed [ChanW+TW:0]   p;
    logic signed [ChanW+TW:0]   d;
    diff  = $signed({1'b0, b}) - $signed({1'b0, a});
    p     = diff * $signed({1'b0, t});
    d     = p >>> 16;
    blend = a + d[ChanW-1:0];
  endfunction

  function automatic logic [ChanW-1:0] mul255(input logic [ChanW-1:0] p,
                                              input logic [ChanW-1:0] q);
    logic [2*ChanW:0] x;
    logic [2*ChanW:0] y;
    x      = (2*ChanW+1)'(p) * (2*ChanW+1)'(q) + (2*ChanW+1)'(127);
    y      = x + (x >> 8) + (2*ChanW+1)'(1);
    mul255 = y[2*ChanW-1:ChanW];
  endfunction

  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  kind_t                  kind1, kind2, kind3;
  rgba_t                  color1, color2, color3;
  logic signed [ProdW-1:0] prod_x, prod_y;
  logic [TW-1:0]          t2;
  rgba_t                  tint3;

  logic signed [SumW-1:0] sum;
  logic signed [SumW-1:0] sum_sh;
  logic [TW-1:0]          t_next;
  rgba_t                  tint_next;
  rgba_t                  out_next;

  assign adv4       = !v4 || out_ready;
  assign adv3       = !v3 || adv4;
  assign adv2       = !v2 || adv3;
  assign adv1       = !v1 || adv2;
  assign item_ready = adv1;
  assign out_valid  = v4;

  always_comb begin
    sum    = SumW'(prod_x) + SumW'(prod_y);
    sum_sh = sum >>> TShift;
    if (sum < 0) begin
      t_next = '0;
    end else if (sum_sh > $signed(SumW'(TOne))) begin
      t_next = TOne;
    end else begin
      t_next = sum_sh[TW-1:0];
    end
  end

  always_comb begin
    case (kind2)
      KIND_LINEAR: begin
        tint_next.red   = blend(cfg.color_start.red,   cfg.color_end.red,   t2);
        tint_next.green = blend(cfg.color_start.green, cfg.color_end.green, t2);
        tint_next.blue  = blend(cfg.color_start.blue,  cfg.color_end.blue,  t2);
        tint_next.alpha = blend(cfg.color_start.alpha, cfg.color_end.alpha, t2);
      end
      default: begin
        tint_next = cfg.color_start;
      end
    endcase
  end

  always_comb begin
    case (kind3)
      KIND_PASS: begin
        out_next = color3;
      end
      default: begin
        out_next.red   = mul255(color3.red,   tint3.red);
        out_next.green = mul255(color3.green, tint3.green);
        out_next.blue  = mul255(color3.blue,  tint3.blue);
        out_next.alpha = mul255(color3.alpha, tint3.alpha);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= item_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        v3 <= v2;
      end
      if (adv4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && item_valid) begin
      kind1  <= item.kind;
      color1 <= item.color;
      prod_x <= item.dx * cfg.grad_x;
      prod_y <= item.dy * cfg.grad_y;
    end
    if (adv2 && v1) begin
      kind2  <= kind1;
      color2 <= color1;
      t2     <= t_next;
    end
    if (adv3 && v2) begin
      kind3  <= kind2;
      color3 <= color2;
      tint3  <= tint_next;
    end
    if (adv4 && v3) begin
      out_color <= out_next;
    end
  end

endmodule

@@ hdl/linear_gradient_color_tint.sv @@
// Throughput: one point per cycle while out_ready holds, set by the single-issue back pipeline.
// A two-entry queue lets the front keep taking points while the back stalls.
// Reset (rst, synchronous): clears all valid state, mode none, start point and
// gradient zero, both colors 0xFFFFFFFF.
// ----------------------------------------------------------------------------
// linear_gradient_color_tint
// Top level: configuration registers, front stage, queue and back datapath.
// ----------------------------------------------------------------------------
module linear_gradient_color_tint import lgct_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CfgIdxW-1:0]     cfg_index,
  input  logic [CfgDataW-1:0]    cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [PosW-1:0] pos_x,
  input  logic signed [PosW-1:0] pos_y,
  input  logic [ChanW-1:0]       in_red,
  input  logic [ChanW-1:0]       in_green,
  input  logic [ChanW-1:0]       in_blue,
  input  logic [ChanW-1:0]       in_alpha,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ChanW-1:0]       out_red,
  output logic [ChanW-1:0]       out_green,
  output logic [ChanW-1:0]       out_blue,
  output logic [ChanW-1:0]       out_alpha
);

  cfg_t  cfg;
  rgba_t in_color;
  rgba_t out_color;
  logic  f_valid, f_ready;
  item_t f_item;
  logic  q_valid, q_ready;
  item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode        <= MODE_NONE;
      cfg.start_x     <= '0;
      cfg.start_y     <= '0;
      cfg.grad_x      <= '0;
      cfg.grad_y      <= '0;
      cfg.color_start <= '1;
      cfg.color_end   <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:        cfg.mode        <= mode_t'(cfg_data[1:0]);
        CFG_START_X:     cfg.start_x     <= cfg_data[PosW-1:0];
        CFG_START_Y:     cfg.start_y     <= cfg_data[PosW-1:0];
        CFG_GRAD_X:      cfg.grad_x      <= cfg_data[GradW-1:0];
        CFG_GRAD_Y:      cfg.grad_y      <= cfg_data[GradW-1:0];
        CFG_COLOR_START: cfg.color_start <= cfg_data;
        CFG_COLOR_END:   cfg.color_end   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_color.red   = in_red;
  assign in_color.green = in_green;
  assign in_color.blue  = in_blue;
  assign in_color.alpha = in_alpha;

  lgct_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .in_color   (in_color),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  lgct_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  lgct_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_color  (out_color)
  );

  assign out_red   = out_color.red;
  assign out_green = out_color.green;
  assign out_blue  = out_color.blue;
  assign out_alpha = out_color.alpha;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the linear gradient color tint block against a predictor of its
// per-channel tint arithmetic. Directed tests cover pass-through, constant
// tint, gradient clamping, a zero gradient, field extremes and the unused
// register index. Random segments then vary the settings under random
// sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import lgct_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;
  localparam int StallPct   = 34;
  localparam int WatchLimit = 4000;
  localparam int SegItems   = 50;
  localparam int SegCount   = 23;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CfgIdxW-1:0]     cfg_index;
  logic [CfgDataW-1:0]    cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic [ChanW-1:0]       in_red;
  logic [ChanW-1:0]       in_green;
  logic [ChanW-1:0]       in_blue;
  logic [ChanW-1:0]       in_alpha;
  logic                   out_valid;
  logic                   out_ready;
  logic [ChanW-1:0]       out_red;
  logic [ChanW-1:0]       out_green;
  logic [ChanW-1:0]       out_blue;
  logic [ChanW-1:0]       out_alpha;

  // Shadow copy of the tint registers
  mode_t                   tint_mode;
  logic signed [PosW-1:0]  origin_x;
  logic signed [PosW-1:0]  origin_y;
  logic signed [GradW-1:0] slope_x;
  logic signed [GradW-1:0] slope_y;
  rgba_t                   color_a;
  rgba_t                   color_b;

  rgba_t expected_colors[$];
  int    errors;
  int    points_sent;
  int    colors_checked;
  int    settings_used;
  bit    sender_stalls;
  bit    receiver_stalls;

  linear_gradient_color_tint dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .in_alpha  (in_alpha),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rgba_t tinted_color(logic signed [PosW-1:0] x, logic signed [PosW-1:0] y,
                                         rgba_t c);
    longint dx;
    longint dy;
    longint s;
    longint t;
    int     a;
    int     b;
    int     p;
    int     q;
    logic [31:0] cv;
    logic [31:0] res;
    if (tint_mode == MODE_NONE) return c;
    cv = c;
    dx = longint'(x) - longint'(origin_x);
    dy = longint'(y) - longint'(origin_y);
    s = dx * longint'(slope_x) + dy * longint'(slope_y);
    if (s < 0) t = 0;
    else t = s >>> TShift;
    if (t > 65536) t = 65536;
    for (int k = 0; k < 4; k++) begin
      a = color_a[31-8*k -: 8];
      b = color_b[31-8*k -: 8];
      p = cv[31-8*k -: 8];
      if (tint_mode == MODE_CONST) q = a;
      else q = a + int'((longint'(b - a) * t) >>> 16);
      res[31-8*k -: 8] = 8'((p * (q & 255) + 127) / 255);
    end
    return rgba_t'(res);
  endfunction

  // Transfer monitor: checks results first, then queues predictions
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected result %h", $time,
                   {out_red, out_green, out_blue, out_alpha});
          errors++;
        end else begin
          rgba_t e;
          e = expected_colors.pop_front();
          colors_checked++;
          if (out_red !== e.red) begin
            $display("%0t: out_red expected %h actual %h", $time, e.red, out_red);
            errors++;
          end
          if (out_green !== e.green) begin
            $display("%0t: out_green expected %h actual %h", $time, e.green, out_green);
            errors++;
          end
          if (out_blue !== e.blue) begin
            $display("%0t: out_blue expected %h actual %h", $time, e.blue, out_blue);
            errors++;
          end
          if (out_alpha !== e.alpha) begin
            $display("%0t: out_alpha expected %h actual %h", $time, e.alpha, out_alpha);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_colors.push_back(tinted_color(pos_x, pos_y,
                                               '{in_red, in_green, in_blue, in_alpha}));
        points_sent++;
      end
    end
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= !receiver_stalls || ($urandom_range(99) >= StallPct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, WatchLimit);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_point(logic signed [PosW-1:0] x, logic signed [PosW-1:0] y, rgba_t c);
    while (sender_stalls && $urandom_range(99) < StallPct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x    <= x;
    pos_y    <= y;
    in_red   <= c.red;
    in_green <= c.green;
    in_blue  <= c.blue;
    in_alpha <= c.alpha;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    // Let the monitor record the last transfer before looking at the queue
    @(posedge clk);
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODE:        tint_mode = mode_t'(data[1:0]);
      CFG_START_X:     origin_x  = data[PosW-1:0];
      CFG_START_Y:     origin_y  = data[PosW-1:0];
      CFG_GRAD_X:      slope_x   = data;
      CFG_GRAD_Y:      slope_y   = data;
      CFG_COLOR_START: color_a   = data;
      CFG_COLOR_END:   color_b   = data;
      default: ;
    endcase
  endtask

  task automatic set_gradient(mode_t m, logic [15:0] sx, logic [15:0] sy,
                              logic [31:0] gx, logic [31:0] gy);
    drain_pipeline();
    write_reg(CFG_MODE, {30'd0, m});
    write_reg(CFG_START_X, {16'd0, sx});
    write_reg(CFG_START_Y, {16'd0, sy});
    write_reg(CFG_GRAD_X, gx);
    write_reg(CFG_GRAD_Y, gy);
    settings_used++;
  endtask

  task automatic set_colors(logic [31:0] ca, logic [31:0] cb);
    drain_pipeline();
    write_reg(CFG_COLOR_START, ca);
    write_reg(CFG_COLOR_END, cb);
  endtask

  task automatic test_passthrough();
    send_point(16'sh7FFF, -16'sh8000, 32'hFFFFFFFF);
    send_point(-16'sh8000, 16'sh7FFF, 32'h00000000);
    send_point(16'sh0000, 16'sh0000, 32'h12345678);
  endtask

  task automatic test_constant_tint();
    set_colors(32'h80FF00C0, 32'h00000000);
    set_gradient(MODE_CONST, 16'h0000, 16'h0000, 32'd0, 32'd0);
    send_point(16'sh0100, 16'sh0100, 32'hFFFFFFFF);
    send_point(16'sh7FFF, 16'sh7FFF, 32'h00000000);
    send_point(-16'sh8000, 16'sh0010, 32'h7F80FF01);
    set_colors(32'h00000000, 32'hFFFFFFFF);
    send_point(16'sh0000, 16'sh0000, 32'hFFFFFFFF);
  endtask

  task automatic test_gradient_clamp();
    // Axis along x, 256 long in Q12.4: t reaches one at dx = 4096
    set_colors(32'h00FF00FF, 32'hFF00FF00);
    set_gradient(MODE_LINEAR, 16'h0000, 16'h0000, 32'd65536, 32'd0);
    send_point(-16'sh0100, 16'sh0000, 32'hFFFFFFFF);
    send_point(16'sh0800, 16'sh1234, 32'hFFFFFFFF);
    send_point(16'sh1000, 16'sh0000, 32'hFFFFFFFF);
    send_point(16'sh7FFF, -16'sh8000, 32'hC0C0C0C0);
    send_point(-16'sh8000, 16'sh7FFF, 32'hFFFFFFFF);
  endtask

  task automatic test_zero_gradient();
    set_colors(32'h4080C0FF, 32'hFFFFFFFF);
    set_gradient(MODE_LOCAL, 16'h0040, 16'hFFC0, 32'd0, 32'd0);
    send_point(16'sh7FFF, 16'sh7FFF, 32'hFFFFFFFF);
    send_point(-16'sh8000, -16'sh8000, 32'hA5A5A5A5);
    send_point(16'sh0040, -16'sh0040, 32'h5A5A5A5A);
  endtask

  task automatic test_field_extremes();
    set_colors(32'hFFFFFFFF, 32'h00000000);
    set_gradient(MODE_LOCAL, 16'h8000, 16'h7FFF, 32'h80000000, 32'h7FFFFFFF);
    send_point(16'sh7FFF, -16'sh8000, 32'hFFFFFFFF);
    send_point(-16'sh8000, 16'sh7FFF, 32'hFFFFFFFF);
    set_gradient(MODE_LINEAR, 16'h7FFF, 16'h8000, 32'h7FFFFFFF, 32'h80000000);
    send_point(-16'sh8000, 16'sh7FFF, 32'hFFFFFFFF);
    send_point(16'sh7FFF, -16'sh8000, 32'h01020304);
  endtask

  task automatic test_unused_index();
    drain_pipeline();
    write_reg(CfgUnused, 32'hDEADBEEF);
    // Upper bits of narrow registers are ignored
    write_reg(CFG_MODE, {30'h3FFFFFFF, MODE_CONST});
    write_reg(CFG_START_X, 32'hABCD0010);
    send_point(16'sh0010, 16'sh0000, 32'hFFFFFFFF);
    send_point(16'sh0000, 16'sh0000, 32'h80808080);
  endtask

  function automatic logic [31:0] random_slope();
    int r;
    logic [31:0] g;
    r = $urandom_range(9);
    if (r == 0) return 32'd0;
    if (r == 1) return $urandom();
    g = $urandom_range(0, 1 << 17);
    return $urandom_range(1) ? -g : g;
  endfunction

  task automatic test_random_segments();
    int          r;
    mode_t       m;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] x;
    logic [15:0] y;
    for (int seg = 0; seg < SegCount; seg++) begin
      // One calm stretch with no stalls on either side
      sender_stalls   = !(seg >= 8 && seg <= 10);
      receiver_stalls = sender_stalls;
      r = $urandom_range(9);
      m = (r == 0) ? MODE_NONE : (r == 1) ? MODE_CONST : (r < 6) ? MODE_LINEAR : MODE_LOCAL;
      sx = 16'($urandom_range(0, 8191)) - 16'd4096;
      sy = 16'($urandom_range(0, 8191)) - 16'd4096;
      if ($urandom_range(4) == 0) begin
        sx = 16'($urandom());
        sy = 16'($urandom());
      end
      set_colors($urandom(), $urandom());
      set_gradient(m, sx, sy, random_slope(), random_slope());
      drain_pipeline();
      write_reg(CFG_MODE, {$urandom() & 32'hFFFFFFFC} | {30'd0, m});
      for (int i = 0; i < SegItems; i++) begin
        if ($urandom_range(4) == 0) begin
          x = 16'($urandom());
          y = 16'($urandom());
        end else begin
          x = sx + 16'($urandom_range(0, 8191)) - 16'd4096;
          y = sy + 16'($urandom_range(0, 8191)) - 16'd4096;
        end
        send_point(x, y, $urandom());
        // Sender holds off mid segment until the pipeline is empty
        if (seg == 3 && i == 24) drain_pipeline();
      end
    end
    sender_stalls   = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  initial begin
    errors          = 0;
    points_sent     = 0;
    colors_checked  = 0;
    settings_used   = 0;
    sender_stalls   = 1'b1;
    receiver_stalls = 1'b1;
    tint_mode       = MODE_NONE;
    origin_x        = '0;
    origin_y        = '0;
    slope_x         = '0;
    slope_y         = '0;
    color_a         = 32'hFFFFFFFF;
    color_b         = 32'hFFFFFFFF;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_MODE;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    pos_x     <= '0;
    pos_y     <= '0;
    in_red    <= '0;
    in_green  <= '0;
    in_blue   <= '0;
    in_alpha  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_passthrough();
    test_constant_tint();
    test_gradient_clamp();
    test_zero_gradient();
    test_field_extremes();
    test_unused_index();
    test_random_segments();

    drain_pipeline();
    repeat (20) @(posedge clk);

    $display("Sent %0d points over %0d gradient settings in all four modes,",
             points_sent, settings_used);
    $display("checked %0d tinted colors with random stalls on both sides.", colors_checked);
    if (errors == 0 && expected_colors.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
